### hdl/rme_pkg.sv
// Shared types, widths and constants for the rotation matrix to Euler angle block.
// Holds the CORDIC arctangent table. No dependencies.
package rme_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN          = 24;
  localparam int STEPS_PER_STAGE  = 2;

  localparam int ENTRY_W = 16;
  localparam int LIMIT_W = 15;
  localparam int OPND_W  = 18;
  localparam int XY_W    = 36;
  localparam int ANG_W   = 28;
  localparam int OUT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int ROOT_W  = 16;
  localparam int SQ_LAT  = 8;

  localparam logic signed [ANG_W-1:0] PI_Q24    = 28'sd52707179;
  localparam logic [ANG_W-12:0]       ANGLE_MAX = 17'd25736;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST = 15'd1;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] r00;
    logic signed [ENTRY_W-1:0] r10;
    logic signed [ENTRY_W-1:0] r20;
    logic signed [ENTRY_W-1:0] r21;
    logic signed [ENTRY_W-1:0] r22;
    logic signed [ENTRY_W-1:0] r12;
    logic signed [ENTRY_W-1:0] r11;
  } mat_t;

  function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/rme_isqrt.sv
// Pipelined integer square root, floor(sqrt(v)) of a 32-bit value.
// Two restoring iterations per stage, SQ_LAT stages. Uses rme_pkg.
module rme_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rme_pkg::SUM_W-1:0]  v_in,
  output logic [rme_pkg::ROOT_W-1:0] root
);
  import rme_pkg::*;

  localparam int W = SUM_W + 1;

  logic [W-1:0] rem [0:SQ_LAT];
  logic [W-1:0] res [0:SQ_LAT];

  assign rem[0] = {1'b0, v_in};
  assign res[0] = '0;

  for (genvar s = 0; s < SQ_LAT; s++) begin : g_stage
    logic [W-1:0] rem_next, res_next;

    always_comb begin
      logic [W-1:0] bitv;
      rem_next = rem[s];
      res_next = res[s];
      for (int k = 0; k < 2; k++) begin
        bitv = W'(1) << (SUM_W - 2 - 2 * (2 * s + k));
        if (rem_next >= res_next + bitv) begin
          rem_next = rem_next - (res_next + bitv);
          res_next = (res_next >> 1) + bitv;
        end else begin
          res_next = res_next >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_next;
        res[s+1] <= res_next;
      end
    end
  end

  assign root = res[SQ_LAT][ROOT_W-1:0];

endmodule

### hdl/rme_cordic.sv
// Pipelined vectoring CORDIC atan2(y, x), Q3.13 radian result.
// Quadrant fold stage, CORDIC_STEPS iterations two per stage, round stage. Uses rme_pkg.
module rme_cordic #(
  parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rme_pkg::OPND_W-1:0] y_in,
  input  logic signed [rme_pkg::OPND_W-1:0] x_in,
  output logic signed [rme_pkg::OUT_W-1:0]  ang_out
);
  import rme_pkg::*;

  localparam int NS = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic signed [XY_W-1:0]  xr [0:NS];
  logic signed [XY_W-1:0]  yr [0:NS];
  logic signed [ANG_W-1:0] ar [0:NS];
  logic                    zr [0:NS];

  // quadrant fold and scale by 2^14
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xr[0] <= XY_W'(-x_in) <<< 14;
        yr[0] <= XY_W'(-y_in) <<< 14;
        ar[0] <= (y_in >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        xr[0] <= XY_W'(x_in) <<< 14;
        yr[0] <= XY_W'(y_in) <<< 14;
        ar[0] <= '0;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic signed [XY_W-1:0]  x_next, y_next;
    logic signed [ANG_W-1:0] a_next;

    always_comb begin
      logic signed [XY_W-1:0] xo;
      int idx;
      x_next = xr[s];
      y_next = yr[s];
      a_next = ar[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        idx = s * STEPS_PER_STAGE + k;
        if (idx < CORDIC_STEPS && idx < TAB_LEN) begin
          xo = x_next;
          if (y_next > 0) begin
            x_next = x_next + (y_next >>> idx);
            y_next = y_next - (xo >>> idx);
            a_next = a_next + atan_tab(idx);
          end else begin
            x_next = x_next - (y_next >>> idx);
            y_next = y_next + (xo >>> idx);
            a_next = a_next - atan_tab(idx);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[s+1] <= x_next;
        yr[s+1] <= y_next;
        ar[s+1] <= a_next;
        zr[s+1] <= zr[s];
      end
    end
  end

  logic [ANG_W-1:0]  mag;
  logic [ANG_W-12:0] rnd, sat;

  always_comb begin
    mag = (ar[NS] < 0) ? ANG_W'(-ar[NS]) : ANG_W'(ar[NS]);
    rnd = (ANG_W-11)'((mag + ANG_W'(1024)) >> 11);
    sat = (rnd > ANGLE_MAX) ? ANGLE_MAX : rnd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[NS]) begin
        ang_out <= '0;
      end else if (ar[NS] < 0) begin
        ang_out <= -OUT_W'(sat);
      end else begin
        ang_out <= OUT_W'(sat);
      end
    end
  end

endmodule

### hdl/rotation_matrix_to_euler.sv
// Rotation matrix (Q1.14) to XYZ Euler angles (Q3.13), fully pipelined.
// Depends on rme_pkg, rme_isqrt and rme_cordic.
//
// Input channel: in_valid/in_stall with seven matrix entries as one word.
// Output channel: out_valid/out_stall with three angles and is_singular.
// Config: cfg_wr_en/cfg_wr_data writes singular_limit (reset value 1);
// write only while the pipeline is empty.
// Throughput: one word per cycle while no result is held at the output by out_stall.
// Stages in order: square and sum, square root, branch select, quadrant fold,
// CORDIC iterations two per stage, rounding.
// The pipeline moves as one: when a result sits at the output and
// out_stall is high, every stage holds and in_stall is raised, so nothing
// is lost or repeated. Reset clears all valid bits and sets the limit to 1.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rme_pkg::LIMIT_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r00,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r10,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r20,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r21,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r22,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r12,
  input  logic signed [rme_pkg::ENTRY_W-1:0] r11,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rme_pkg::OUT_W-1:0]   angle_x,
  output logic signed [rme_pkg::OUT_W-1:0]   angle_y,
  output logic signed [rme_pkg::OUT_W-1:0]   angle_z,
  output logic                               is_singular
);
  import rme_pkg::*;

  localparam int NS    = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DEPTH = 13 + NS;
  localparam int MDLY  = 2 + SQ_LAT;
  localparam int SDLY  = NS + 2;

  logic                 adv;
  logic [DEPTH-1:0]     vld;
  logic [LIMIT_W-1:0]   singular_limit;
  mat_t                 mat_in;
  mat_t                 mdly [0:MDLY-1];
  logic [SUM_W-2:0]     sq00, sq10;
  logic [SUM_W-1:0]     sum;
  logic [ROOT_W-1:0]    sy;
  logic                 sing_next, sing;
  logic                 sdly [0:SDLY-1];
  logic signed [OPND_W-1:0] xa_y, xa_x, ya_y, ya_x, za_y, za_x;
  logic signed [2*ENTRY_W-1:0] p00, p10;

  assign adv       = !vld[DEPTH-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[DEPTH-1];

  assign mat_in = '{r00: r00, r10: r10, r20: r20, r21: r21,
                    r22: r22, r12: r12, r11: r11};

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_limit <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      singular_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  assign p00 = r00 * r00;
  assign p10 = r10 * r10;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq00 <= p00[SUM_W-2:0];
      sq10 <= p10[SUM_W-2:0];
      sum  <= SUM_W'(sq00) + SUM_W'(sq10);
      mdly[0] <= mat_in;
      for (int i = 1; i < MDLY; i++) begin
        mdly[i] <= mdly[i-1];
      end
    end
  end

  rme_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .v_in (sum),
    .root (sy)
  );

  assign sing_next = (ROOT_W+1)'(sy) < (ROOT_W+1)'(singular_limit);

  always_ff @(posedge clk) begin
    if (adv) begin
      sing <= sing_next;
      ya_y <= -OPND_W'(mdly[MDLY-1].r20);
      ya_x <= OPND_W'({1'b0, sy});
      if (sing_next) begin
        xa_y <= -OPND_W'(mdly[MDLY-1].r12);
        xa_x <= OPND_W'(mdly[MDLY-1].r11);
        za_y <= '0;
        za_x <= '0;
      end else begin
        xa_y <= OPND_W'(mdly[MDLY-1].r21);
        xa_x <= OPND_W'(mdly[MDLY-1].r22);
        za_y <= OPND_W'(mdly[MDLY-1].r10);
        za_x <= OPND_W'(mdly[MDLY-1].r00);
      end
      sdly[0] <= sing;
      for (int i = 1; i < SDLY; i++) begin
        sdly[i] <= sdly[i-1];
      end
    end
  end

  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_x (
    .clk (clk), .en (adv), .y_in (xa_y), .x_in (xa_x), .ang_out (angle_x)
  );

  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_y (
    .clk (clk), .en (adv), .y_in (ya_y), .x_in (ya_x), .ang_out (angle_y)
  );

  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_z (
    .clk (clk), .en (adv), .y_in (za_y), .x_in (za_x), .ang_out (angle_z)
  );

  assign is_singular = sdly[SDLY-1];

endmodule

### test/testbench.sv
// Testbench for rotation_matrix_to_euler: random and directed matrices,
// checked against a bit-exact CORDIC predictor. Depends on rme_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import rme_pkg::*;

  localparam int STEPS = 16;
  localparam int LAT   = 30;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               sing;
  } angles_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] r00 = 0, r10 = 0, r20 = 0, r21 = 0, r22 = 0, r12 = 0, r11 = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] angle_x, angle_y, angle_z;
  logic is_singular;

  rotation_matrix_to_euler i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .r00(r00), .r10(r10), .r20(r20), .r21(r21), .r22(r22), .r12(r12), .r11(r11),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
    .is_singular(is_singular)
  );

  always #4 clk = ~clk;

  mat_t    pending_mats[$];
  angles_t expected_angles[$];
  logic [LIMIT_W-1:0] limit_model = LIMIT_RST;
  int errors = 0;
  int n_matched = 0;
  int n_singular = 0;
  int send_gap_max = 15;
  int recv_gap_max = 15;
  int hold_cycles = 0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] cordic_atan2(longint y, longint x);
    longint ang, xs, ys, mag, r;
    ang = 0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      ang = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; ang = ang + longint'(atan_tab(i));
      end else begin
        x = x - ys; y = y + xs; ang = ang - longint'(atan_tab(i));
      end
    end
    mag = ang < 0 ? -ang : ang;
    r = (mag + 1024) >>> 11;
    if (r > 25736) r = 25736;
    return ang < 0 ? 16'(-r) : 16'(r);
  endfunction

  function automatic angles_t euler_of(mat_t m, logic [LIMIT_W-1:0] lim);
    angles_t a;
    longint sum, sy;
    sum = longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10;
    sy = 0;
    while ((sy + 1) * (sy + 1) <= sum) sy++;
    a.sing = sy < longint'(lim);
    a.ay = cordic_atan2(-longint'(m.r20), sy);
    if (!a.sing) begin
      a.ax = cordic_atan2(m.r21, m.r22);
      a.az = cordic_atan2(m.r10, m.r00);
    end else begin
      a.ax = cordic_atan2(-longint'(m.r12), m.r11);
      a.az = 0;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  int send_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_angles.push_back(euler_of({r00, r10, r20, r21, r22, r12, r11},
                                           limit_model));
        pending_mats.pop_front();
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 0;
        end else if (pending_mats.size() > 0 && !(in_valid && !in_stall &&
                     pending_mats.size() == 0)) begin
          in_valid <= 1;
          {r00, r10, r20, r21, r22, r12, r11} <= pending_mats[0];
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  int recv_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          angles_t e;
          e = expected_angles.pop_front();
          if (angle_x !== e.ax) report_mismatch("angle_x", angle_x, e.ax);
          if (angle_y !== e.ay) report_mismatch("angle_y", angle_y, e.ay);
          if (angle_z !== e.az) report_mismatch("angle_z", angle_z, e.az);
          if (is_singular !== e.sing) report_mismatch("is_singular", is_singular, e.sing);
          n_matched++;
          if (e.sing) n_singular++;
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // rotation-like matrix from random angles, optionally with y near plus or minus pi/2
  function automatic mat_t rand_rotation(bit near_lock);
    mat_t m;
    real x, y, z;
    x = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
    z = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
    y = near_lock ? ($urandom_range(0, 1) ? 1.5707 : -1.5707)
                  : ($urandom_range(0, 31415) / 10000.0) - 1.5707;
    m.r00 = 16'($rtoi(16384.0 * $cos(y) * $cos(z)));
    m.r10 = 16'($rtoi(16384.0 * $cos(y) * $sin(z)));
    m.r20 = 16'($rtoi(-16384.0 * $sin(y)));
    m.r21 = 16'($rtoi(16384.0 * $cos(y) * $sin(x)));
    m.r22 = 16'($rtoi(16384.0 * $cos(y) * $cos(x)));
    m.r12 = 16'($rtoi(16384.0 * ($cos(z) * $sin(y) * $sin(x) - $sin(z) * $cos(x))));
    m.r11 = 16'($rtoi(16384.0 * ($sin(z) * $sin(y) * $sin(x) + $cos(z) * $cos(x))));
    return m;
  endfunction

  task automatic drain();
    while (pending_mats.size() > 0 || in_valid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    limit_model = v;
    @(posedge clk);
  endtask

  initial begin
    mat_t m;
    logic [LIMIT_W-1:0] limits[5] = '{15'd1, 15'd0, 15'd16384, 15'd200, 15'd32767};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zeros, negative x axis, out of range, singular
    pending_mats.push_back('{16384, 0, 0, 0, 16384, 0, 16384});
    pending_mats.push_back('0);
    pending_mats.push_back('{-16384, 0, 0, 0, -16384, 0, -16384});
    pending_mats.push_back('{-16384, 0, 16384, 0, -16384, 0, -16384});
    pending_mats.push_back('{0, 0, -16384, 16384, 0, -16384, 0});
    pending_mats.push_back('{0, 0, 16384, -16384, 0, 16384, 0});
    pending_mats.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, -32768});
    pending_mats.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767});
    pending_mats.push_back('{-32768, 32767, 32767, -32768, 32767, -32768, 32767});
    pending_mats.push_back('{1, 0, 0, 0, -5, 0, -7});
    pending_mats.push_back('{0, 1, -1, 1, 1, 1, 1});
    pending_mats.push_back('{-1, 0, 0, 0, -1, 0, -1});
    pending_mats.push_back('{-16384, -1, 1, -1, -16384, 1, -16384});
    drain();

    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      for (int i = 0; i < 180; i++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            m = '0;
            m.r00 = rand_entry(); m.r10 = rand_entry(); m.r20 = rand_entry();
            m.r21 = rand_entry(); m.r22 = rand_entry(); m.r12 = rand_entry();
            m.r11 = rand_entry();
          end
          2: m = rand_rotation(1);
          default: m = rand_rotation(0);
        endcase
        pending_mats.push_back(m);
        if (p == 1 && i == 60) begin
          send_gap_max = 0;
          recv_gap_max = 0;
          hold_cycles = 80;
        end
        if (p == 2 && i == 0) begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        if (p == 3 && i == 0) begin
          send_gap_max = 15;
          recv_gap_max = 15;
        end
      end
      drain();
    end

    $display("checked %0d result words, %0d singular, over five threshold settings",
             n_matched, n_singular);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
